// File: design/clr_pkg.sv
`timescale 1ns / 1ps
package clr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS_DEF = 16;
  localparam int REG_BITS       = 11;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [REG_BITS-1:0] WIDTH_RST  = REG_BITS'(320);
  localparam logic [REG_BITS-1:0] HEIGHT_RST = REG_BITS'(240);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

endpackage

// File: design/clipped_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer with per-pixel clipping. A start item (operation 0) loads
// two endpoints and a colour and produces no result; each step item (operation 1)
// while a line is active produces one pixel, with last_pixel on the final one; a
// step with no active line produces nothing. Takes one item per clock: the error term
// add-compare-update is combinational and the pixel lands in an output
// register, so in_stall is only raised while that register is full and out_stall is
// high. Diagonal pixels are clipped one by one against screen_width/screen_height as
// they stand at each step; horizontal and vertical lines run from the smaller to the
// larger coordinate and are entirely hidden when their far end is off screen, judged
// at start. Configuration writes are always ready and take effect on the next item.
module clipped_line_rasterizer_unit #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = clr_pkg::COLOR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [COORD_BITS-1:0]            in_start_x,
  input  logic [COORD_BITS-1:0]            in_start_y,
  input  logic [COORD_BITS-1:0]            in_end_x,
  input  logic [COORD_BITS-1:0]            in_end_y,
  input  logic [COLOR_BITS-1:0]            in_line_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_BITS-1:0]            out_pixel_x,
  output logic [COORD_BITS-1:0]            out_pixel_y,
  output logic [COLOR_BITS-1:0]            out_pixel_color,
  output logic                             out_visible,
  output logic                             out_last_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [clr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [clr_pkg::REG_BITS-1:0]     cfg_data
);
  import clr_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int CMP_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;

  logic [REG_BITS-1:0] scr_w_r, scr_h_r;

  logic                       busy_r;
  logic [COORD_BITS-1:0]      cur_x_r, cur_y_r, tgt_x_r, tgt_y_r, dx_r, dy_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic                       neg_x_r, neg_y_r, x_major_r, aa_hidden_r;
  logic [COLOR_BITS-1:0]      color_r;

  logic                       busy_nxt;
  logic [COORD_BITS-1:0]      cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt, dx_nxt, dy_nxt;
  logic signed [ERR_BITS-1:0] err_nxt;
  logic                       neg_x_nxt, neg_y_nxt, x_major_nxt, aa_hidden_nxt;
  logic [COLOR_BITS-1:0]      color_nxt;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_vis_r, out_last_r;

  logic accept, do_start, do_step;

  // start decode
  logic                       s_aa;
  logic [COORD_BITS-1:0]      s_x0, s_y0, s_x1, s_y1, s_dx, s_dy, s_major, s_minor;
  logic                       s_neg_x, s_neg_y, s_xmaj;

  // step decode
  logic                       last, vis;
  logic signed [ERR_BITS-1:0] dbl_dx, dbl_dy, err_adj;
  logic [COORD_BITS-1:0]      mv_x, mv_y;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign do_start  = accept & (in_operation == OP_START);
  assign do_step   = accept & (in_operation == OP_STEP) & busy_r;

  always_comb begin
    s_aa = (in_start_x == in_end_x) || (in_start_y == in_end_y);
    if (s_aa && (in_start_x > in_end_x)) begin
      s_x0 = in_end_x;
      s_x1 = in_start_x;
    end else begin
      s_x0 = in_start_x;
      s_x1 = in_end_x;
    end
    if (s_aa && (in_start_y > in_end_y)) begin
      s_y0 = in_end_y;
      s_y1 = in_start_y;
    end else begin
      s_y0 = in_start_y;
      s_y1 = in_end_y;
    end
    s_neg_x = s_x1 < s_x0;
    s_neg_y = s_y1 < s_y0;
    s_dx    = s_neg_x ? (s_x0 - s_x1) : (s_x1 - s_x0);
    s_dy    = s_neg_y ? (s_y0 - s_y1) : (s_y1 - s_y0);
    s_xmaj  = s_dx > s_dy;
    s_major = s_xmaj ? s_dx : s_dy;
    s_minor = s_xmaj ? s_dy : s_dx;
  end

  always_comb begin
    last   = x_major_r ? (cur_x_r == tgt_x_r) : (cur_y_r == tgt_y_r);
    vis    = ~aa_hidden_r && (CMP_BITS'(cur_x_r) < CMP_BITS'(scr_w_r))
                          && (CMP_BITS'(cur_y_r) < CMP_BITS'(scr_h_r));
    dbl_dx = $signed({2'b00, dx_r, 1'b0});
    dbl_dy = $signed({2'b00, dy_r, 1'b0});
    mv_x   = neg_x_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
    mv_y   = neg_y_r ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
    err_adj = err_r;
  end

  always_comb begin
    busy_nxt      = busy_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    err_nxt       = err_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    x_major_nxt   = x_major_r;
    aa_hidden_nxt = aa_hidden_r;
    color_nxt     = color_r;
    if (do_start) begin
      busy_nxt      = 1'b1;
      cur_x_nxt     = s_x0;
      cur_y_nxt     = s_y0;
      tgt_x_nxt     = s_x1;
      tgt_y_nxt     = s_y1;
      dx_nxt        = s_dx;
      dy_nxt        = s_dy;
      neg_x_nxt     = s_neg_x;
      neg_y_nxt     = s_neg_y;
      x_major_nxt   = s_xmaj;
      color_nxt     = in_line_color;
      aa_hidden_nxt = s_aa && ((CMP_BITS'(s_x1) >= CMP_BITS'(scr_w_r))
                            || (CMP_BITS'(s_y1) >= CMP_BITS'(scr_h_r)));
      err_nxt       = $signed({2'b00, s_minor, 1'b0}) - $signed({3'b000, s_major});
    end else if (do_step) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (x_major_r) begin
        if (err_r >= 0) begin
          cur_y_nxt = mv_y;
          err_nxt   = err_adj - dbl_dx + dbl_dy;
        end else begin
          err_nxt   = err_adj + dbl_dy;
        end
        cur_x_nxt = mv_x;
      end else begin
        if (err_r >= 0) begin
          cur_x_nxt = mv_x;
          err_nxt   = err_adj - dbl_dy + dbl_dx;
        end else begin
          err_nxt   = err_adj + dbl_dx;
        end
        cur_y_nxt = mv_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= WIDTH_RST;
      scr_h_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      err_r       <= '0;
      neg_x_r     <= 1'b0;
      neg_y_r     <= 1'b0;
      x_major_r   <= 1'b0;
      aa_hidden_r <= 1'b0;
      color_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      err_r       <= err_nxt;
      neg_x_r     <= neg_x_nxt;
      neg_y_r     <= neg_y_nxt;
      x_major_r   <= x_major_nxt;
      aa_hidden_r <= aa_hidden_nxt;
      color_r     <= color_nxt;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= color_r;
      out_vis_r   <= vis;
      out_last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_visible     = out_vis_r;
  assign out_last_pixel  = out_last_r;

endmodule
